// ----- sv/page_allocator_refcount_macros.svh -----
// assertion macros for the page allocator checker
// expects signals clk and rst_n in the scope of use
`ifndef PAGE_ALLOCATOR_REFCOUNT_MACROS_SVH
`define PAGE_ALLOCATOR_REFCOUNT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PGAR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgar check failed");

// next-cycle implication, disabled during reset
`define PGAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgar check failed");

`endif

// ----- sv/pgar_pkg.sv -----
// shared types and constants of the page allocator
// no dependencies
`default_nettype none

package pgar_pkg;

    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int DEPTH_W    = PAGE_W + 1;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 40;
    localparam int FIRST_W    = 10;
    localparam int CNT_W      = 8;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;

    // ops
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_INCREF = 2'd2;
    localparam logic [OP_W-1:0] OP_INIT   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE  = 1'd1;

    // region bounds carry one extra bit so the top never wraps
    localparam logic [ADDR_W-1:0] REGION_BASE_RST = 40'h00_8000_0000;
    localparam logic [ADDR_W:0]   REGION_SPAN     = (ADDR_W+1)'(NUM_PAGES) << PAGE_SHIFT;

    localparam logic [CNT_W-1:0] CNT_ONE = 8'd1;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    typedef struct packed {
        logic                cnt_we;
        logic [PAGE_W-1:0]   cnt_addr;
        logic [CNT_W-1:0]    cnt_data;
        logic                stk_we;
        logic [PAGE_W-1:0]   stk_addr;
        logic [PAGE_W-1:0]   stk_data;
        logic [DEPTH_W-1:0]  depth;
    } upd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   page_address;
        logic [STATUS_W-1:0] status;
        logic                page_freed;
        logic [CNT_W-1:0]    count_after;
    } res_t;

endpackage

`default_nettype wire

// ----- sv/pgar_ram.sv -----
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
`default_nettype none

module pgar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/pgar_exec.sv -----
// per-op modify stage: turns read data and latched item into writes and a result
// depends on pgar_pkg
`default_nettype none

module pgar_exec (
    input  wire logic [pgar_pkg::OP_W-1:0]    op,
    input  wire logic [pgar_pkg::ADDR_W-1:0]  addr,
    input  wire logic [pgar_pkg::PAGE_W-1:0]  idx,
    input  wire logic [pgar_pkg::CNT_W-1:0]   cnt_rd,
    input  wire logic [pgar_pkg::PAGE_W-1:0]  stk_rd,
    input  wire logic [pgar_pkg::DEPTH_W-1:0] depth,
    input  wire logic [pgar_pkg::ADDR_W-1:0]  region_base,
    input  wire logic [pgar_pkg::ADDR_W:0]    low_bound,
    input  wire logic [pgar_pkg::ADDR_W:0]    top_bound,
    output pgar_pkg::upd_t                    upd,
    output pgar_pkg::res_t                    res
);

    localparam int PAD_W = pgar_pkg::ADDR_W - pgar_pkg::PAGE_W - pgar_pkg::PAGE_SHIFT;

    logic [pgar_pkg::ADDR_W:0]  addr_x;
    logic [pgar_pkg::CNT_W-1:0] cnt_dec;
    logic [pgar_pkg::CNT_W-1:0] cnt_inc;
    logic                       misaligned;
    logic                       stack_full;

    assign addr_x     = {1'b0, addr};
    assign cnt_dec    = cnt_rd - pgar_pkg::CNT_ONE;
    assign cnt_inc    = cnt_rd + pgar_pkg::CNT_ONE;
    assign misaligned = |addr[pgar_pkg::PAGE_SHIFT-1:0];
    assign stack_full = (depth >= pgar_pkg::DEPTH_W'(pgar_pkg::NUM_PAGES));

    always_comb
    begin
        upd          = '0;
        upd.depth    = depth;
        upd.cnt_addr = idx;
        upd.stk_addr = depth[pgar_pkg::PAGE_W-1:0];
        upd.stk_data = idx;
        res          = '0;
        res.status   = pgar_pkg::ST_OK;
        case (op)
            pgar_pkg::OP_ALLOC:
            begin
                if (depth == '0)
                begin
                    res.status = pgar_pkg::ST_OOM;
                end
                else
                begin
                    upd.depth        = depth - 1'b1;
                    upd.cnt_we       = 1'b1;
                    upd.cnt_addr     = stk_rd;
                    upd.cnt_data     = pgar_pkg::CNT_ONE;
                    res.page_address = region_base +
                        {{PAD_W{1'b0}}, stk_rd, {pgar_pkg::PAGE_SHIFT{1'b0}}};
                    res.count_after  = pgar_pkg::CNT_ONE;
                end
            end
            pgar_pkg::OP_FREE:
            begin
                if (misaligned || addr_x < low_bound || addr_x >= top_bound)
                begin
                    res.status = pgar_pkg::ST_BAD_ADDR;
                end
                else if (cnt_rd == '0)
                begin
                    res.status = pgar_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    upd.cnt_we      = 1'b1;
                    upd.cnt_data    = cnt_dec;
                    res.count_after = cnt_dec;
                    // last reference gone: push back unless the stack is full
                    if (cnt_dec == '0 && !stack_full)
                    begin
                        upd.stk_we     = 1'b1;
                        upd.depth      = depth + 1'b1;
                        res.page_freed = 1'b1;
                    end
                end
            end
            pgar_pkg::OP_INCREF:
            begin
                if (addr < region_base)
                begin
                    res.status = pgar_pkg::ST_OK;
                end
                else if (addr_x >= top_bound)
                begin
                    res.status = pgar_pkg::ST_BAD_ADDR;
                end
                else if (cnt_rd == pgar_pkg::CNT_MAX)
                begin
                    res.status      = pgar_pkg::ST_OVERFLOW;
                    res.count_after = pgar_pkg::CNT_MAX;
                end
                else
                begin
                    upd.cnt_we      = 1'b1;
                    upd.cnt_data    = cnt_inc;
                    res.count_after = cnt_inc;
                end
            end
            default:
            begin
                // init: the sweep did the work, result is all zero
                res.status = pgar_pkg::ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/page_allocator_refcount.sv -----
// page allocator with per-page reference counts, top level
// depends on pgar_pkg, pgar_ram, pgar_exec
//
// usage
// - input channel (in_valid / in_stall) carries op and address; a transfer
//   happens on a rising edge with in_valid high and in_stall low
// - output channel (out_valid / out_stall) carries page_address, status,
//   page_freed and count_after; one result per input item, in order
// - cfg_we / cfg_index / cfg_data write region_base (index 0) and
//   first_page (index 1); write only while the block is idle
// - alloc, free and incref: the transfer edge issues the count and stack
//   memory reads; in S_EXEC, once the output register is free or leaving,
//   the read-modify-write is done and the output register is loaded
// - init sweeps pages first_page .. NUM_PAGES-1, writing one count and one
//   stack entry a cycle, then ends in S_EXEC
// - after reset a clearing pass zeroes the count memory with in_stall high;
//   config writes are taken during it
// - the output register holds a finished result while out_stall is high;
//   the next item is still taken, and its write-back waits until the
//   held result leaves
`default_nettype none

module page_allocator_refcount (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [pgar_pkg::OP_W-1:0]         op,
    input  wire logic [pgar_pkg::ADDR_W-1:0]       address,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [pgar_pkg::ADDR_W-1:0]            page_address,
    output logic [pgar_pkg::STATUS_W-1:0]          status,
    output logic                                   page_freed,
    output logic [pgar_pkg::CNT_W-1:0]             count_after,
    input  wire logic                              cfg_we,
    input  wire logic [pgar_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pgar_pkg::ADDR_W-1:0]       cfg_data
);

    // controller states
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_INIT  = 2'd3;

    localparam logic [pgar_pkg::PAGE_W-1:0] LAST_PAGE = pgar_pkg::PAGE_W'(pgar_pkg::NUM_PAGES - 1);

    logic [1:0]                        state_reg, state_next;
    logic [pgar_pkg::PAGE_W-1:0]       sweep_reg, sweep_next;
    logic [pgar_pkg::DEPTH_W-1:0]      depth_reg, depth_next;

    // config and derived bounds
    logic [pgar_pkg::ADDR_W-1:0]       region_base_reg;
    logic [pgar_pkg::FIRST_W-1:0]      first_page_reg;
    logic [pgar_pkg::ADDR_W:0]         low_reg;
    logic [pgar_pkg::ADDR_W:0]         top_reg;

    // latched item
    logic [pgar_pkg::OP_W-1:0]         op_reg;
    logic [pgar_pkg::ADDR_W-1:0]       addr_reg;
    logic [pgar_pkg::PAGE_W-1:0]       idx_reg;

    // output register
    logic                              out_valid_reg;
    pgar_pkg::res_t                    res_reg;

    logic                              in_xfer;
    logic                              out_xfer;
    logic                              exec_go;
    logic                              first_in_range;
    logic [pgar_pkg::ADDR_W-1:0]       addr_diff;
    logic [pgar_pkg::PAGE_W-1:0]       in_idx;
    logic [pgar_pkg::DEPTH_W-1:0]      depth_m1;
    logic [pgar_pkg::ADDR_W:0]         first_offset_cfg;
    logic [pgar_pkg::ADDR_W:0]         first_offset_cur;

    // memory ports
    logic                              cnt_we;
    logic [pgar_pkg::PAGE_W-1:0]       cnt_waddr;
    logic [pgar_pkg::CNT_W-1:0]        cnt_wdata;
    logic [pgar_pkg::CNT_W-1:0]        cnt_rdata;
    logic                              stk_we;
    logic [pgar_pkg::PAGE_W-1:0]       stk_waddr;
    logic [pgar_pkg::PAGE_W-1:0]       stk_wdata;
    logic [pgar_pkg::PAGE_W-1:0]       stk_rdata;

    pgar_pkg::upd_t                    upd;
    pgar_pkg::res_t                    res;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    // write-back may happen once the output register is free or leaving
    assign exec_go   = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    assign first_in_range = (32'(first_page_reg) < pgar_pkg::NUM_PAGES);

    // page index of the incoming address, used only when in range
    assign addr_diff = address - region_base_reg;
    assign in_idx    = addr_diff[pgar_pkg::PAGE_SHIFT +: pgar_pkg::PAGE_W];
    assign depth_m1  = depth_reg - 1'b1;

    assign first_offset_cfg = (pgar_pkg::ADDR_W+1)'(cfg_data[pgar_pkg::FIRST_W-1:0])
                              << pgar_pkg::PAGE_SHIFT;
    assign first_offset_cur = (pgar_pkg::ADDR_W+1)'(first_page_reg) << pgar_pkg::PAGE_SHIFT;

    // ---------------- config registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= pgar_pkg::REGION_BASE_RST;
            first_page_reg  <= '0;
            low_reg         <= {1'b0, pgar_pkg::REGION_BASE_RST};
            top_reg         <= {1'b0, pgar_pkg::REGION_BASE_RST} + pgar_pkg::REGION_SPAN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pgar_pkg::CFG_REGION_BASE:
                begin
                    region_base_reg <= cfg_data;
                    low_reg         <= {1'b0, cfg_data} + first_offset_cur;
                    top_reg         <= {1'b0, cfg_data} + pgar_pkg::REGION_SPAN;
                end
                pgar_pkg::CFG_FIRST_PAGE:
                begin
                    first_page_reg <= cfg_data[pgar_pkg::FIRST_W-1:0];
                    low_reg        <= {1'b0, region_base_reg} + first_offset_cfg;
                end
                default:
                begin
                    region_base_reg <= region_base_reg;
                end
            endcase
        end
    end

    // ---------------- controller ----------------
    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        depth_next = depth_reg;
        case (state_reg)
            S_CLEAR:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_PAGE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (op == pgar_pkg::OP_INIT)
                    begin
                        depth_next = '0;
                        sweep_next = pgar_pkg::PAGE_W'(first_page_reg);
                        state_next = first_in_range ? S_INIT : S_EXEC;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_INIT:
            begin
                sweep_next = sweep_reg + 1'b1;
                depth_next = depth_reg + 1'b1;
                if (sweep_reg == LAST_PAGE)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    depth_next = upd.depth;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            sweep_reg <= '0;
            depth_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            depth_reg <= depth_next;
        end
    end

    // item latch, payload only
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= op;
            addr_reg <= address;
            idx_reg  <= in_idx;
        end
    end

    // ---------------- memory write selection ----------------
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = upd.cnt_addr;
        cnt_wdata = upd.cnt_data;
        stk_we    = 1'b0;
        stk_waddr = upd.stk_addr;
        stk_wdata = upd.stk_data;
        case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = sweep_reg;
                cnt_wdata = '0;
            end
            S_INIT:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = sweep_reg;
                cnt_wdata = '0;
                stk_we    = 1'b1;
                stk_waddr = depth_reg[pgar_pkg::PAGE_W-1:0];
                stk_wdata = sweep_reg;
            end
            S_EXEC:
            begin
                cnt_we = exec_go && upd.cnt_we;
                stk_we = exec_go && upd.stk_we;
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    pgar_ram #(
        .WIDTH (pgar_pkg::CNT_W),
        .DEPTH (pgar_pkg::NUM_PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (in_xfer),
        .raddr (in_idx),
        .rdata (cnt_rdata)
    );

    pgar_ram #(
        .WIDTH (pgar_pkg::PAGE_W),
        .DEPTH (pgar_pkg::NUM_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (in_xfer),
        .raddr (depth_m1[pgar_pkg::PAGE_W-1:0]),
        .rdata (stk_rdata)
    );

    pgar_exec u_exec (
        .op          (op_reg),
        .addr        (addr_reg),
        .idx         (idx_reg),
        .cnt_rd      (cnt_rdata),
        .stk_rd      (stk_rdata),
        .depth       (depth_reg),
        .region_base (region_base_reg),
        .low_bound   (low_reg),
        .top_bound   (top_reg),
        .upd         (upd),
        .res         (res)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign page_address = res_reg.page_address;
    assign status       = res_reg.status;
    assign page_freed   = res_reg.page_freed;
    assign count_after  = res_reg.count_after;

endmodule

`default_nettype wire

// ----- sv/pgar_checker.sv -----
// port-level checker for the page allocator, bound to the top level
// depends on pgar_pkg and page_allocator_refcount_macros.svh
`default_nettype none

`include "page_allocator_refcount_macros.svh"

module pgar_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [pgar_pkg::ADDR_W-1:0]       page_address,
    input wire logic [pgar_pkg::STATUS_W-1:0]     status,
    input wire logic                              page_freed,
    input wire logic [pgar_pkg::CNT_W-1:0]        count_after
);

    // a held result stays offered
    `PGAR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // a held result does not change
    `PGAR_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(page_address) && $stable(status) && $stable(page_freed) && $stable(count_after))

    // only a successful alloc hands out an address
    `PGAR_ASSERT_NOW(a_addr_ok_only, out_valid && status != pgar_pkg::ST_OK,
        page_address == '0 && !page_freed)

    // a pushed page has no references left, and an overflow reports the ceiling
    `PGAR_ASSERT_NOW(a_freed_zero, out_valid && (page_freed || status == pgar_pkg::ST_OVERFLOW),
        (page_freed && status == pgar_pkg::ST_OK && count_after == '0) ||
        (!page_freed && count_after == pgar_pkg::CNT_MAX))

endmodule

bind page_allocator_refcount pgar_checker u_pgar_checker (.*);

`default_nettype wire
